### src/sblt_pkg.sv
// ----------------------------------------------------------------------------
// sblt_pkg: shared types and constants for the slotted bounded list table
// Sizes, operation kinds, status codes and the sequencer control struct.
// ----------------------------------------------------------------------------
package sblt_pkg;
    localparam int NUM_SLOTS  = 10;
    localparam int SLOT_DEPTH = 16;
    localparam int SLOT_W     = 4;
    localparam int KIND_W     = 3;
    localparam int AMT_W      = 7;
    localparam int DATA_W     = 32;
    localparam int STAT_W     = 4;
    localparam int FILL_W     = $clog2(SLOT_DEPTH + 1);
    localparam int SIDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int EIDX_W     = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int MEM_DEPTH  = NUM_SLOTS * SLOT_DEPTH;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    // operation kinds
    localparam logic [KIND_W-1:0] K_CREATE = 3'd0;
    localparam logic [KIND_W-1:0] K_INSERT = 3'd1;
    localparam logic [KIND_W-1:0] K_DELL   = 3'd2;
    localparam logic [KIND_W-1:0] K_DELV   = 3'd3;
    localparam logic [KIND_W-1:0] K_RESIZE = 3'd4;
    localparam logic [KIND_W-1:0] K_READ   = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK           = 4'd0;
    localparam logic [STAT_W-1:0] ST_BAD_SLOT     = 4'd1;
    localparam logic [STAT_W-1:0] ST_EXISTS       = 4'd2;
    localparam logic [STAT_W-1:0] ST_NO_LIST      = 4'd3;
    localparam logic [STAT_W-1:0] ST_FULL         = 4'd4;
    localparam logic [STAT_W-1:0] ST_EMPTY        = 4'd5;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND    = 4'd6;
    localparam logic [STAT_W-1:0] ST_BAD_SIZE     = 4'd7;
    localparam logic [STAT_W-1:0] ST_BAD_NEW_SIZE = 4'd8;
    localparam logic [STAT_W-1:0] ST_NO_MEMORY    = 4'd9;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [FILL_W-1:0] fill;
        logic [DATA_W-1:0] data;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [AMT_W-1:0]  amount;
        logic [DATA_W-1:0] value;
    } t_item;

    // element memory port request from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    function automatic logic [ADDR_W-1:0] elem_addr(logic [SIDX_W-1:0] s,
                                                    logic [EIDX_W-1:0] i);
        logic [ADDR_W+SIDX_W:0] a;
        a = (ADDR_W+SIDX_W+1)'(s) * (ADDR_W+SIDX_W+1)'(SLOT_DEPTH)
            + (ADDR_W+SIDX_W+1)'(i);
        return a[ADDR_W-1:0];
    endfunction
endpackage

### src/sblt_if.sv
// ----------------------------------------------------------------------------
// sblt_if: valid/ready channel
// Carries one payload type per instance, with source and sink modports.
// ----------------------------------------------------------------------------
interface sblt_item_if;
    import sblt_pkg::*;
    logic  valid;
    logic  ready;
    t_item payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface sblt_result_if;
    import sblt_pkg::*;
    logic    valid;
    logic    ready;
    t_result payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### src/sblt_ram.sv
// ----------------------------------------------------------------------------
// sblt_ram: generic single-write, single-read RAM
// Registered read data, no reset on contents.
// ----------------------------------------------------------------------------
module sblt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 160
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

### src/sblt_seq.sv
// ----------------------------------------------------------------------------
// sblt_seq: operation sequencer
// Holds slot descriptors, checks each item and walks the slot memory one word
// per cycle for search, shift-down and read streaming while the output is not stalled.
// ----------------------------------------------------------------------------
module sblt_seq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    sblt_item_if.sink          s_in,
    sblt_result_if.source      m_out,
    output sblt_pkg::t_mem_req o_mem,
    input  logic [sblt_pkg::DATA_W-1:0] i_rdata
);
    import sblt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_FIND  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]        r_state, n_state;
    logic              r_alloc [NUM_SLOTS];
    logic [FILL_W-1:0] r_cap   [NUM_SLOTS];
    logic [FILL_W-1:0] r_fill  [NUM_SLOTS];
    t_item             r_item;
    logic [SIDX_W-1:0] r_s;
    logic [FILL_W-1:0] r_n;
    logic [FILL_W-1:0] r_i;    // next address issued
    logic              r_pend; // read data valid this cycle for index r_j
    logic [FILL_W-1:0] r_j;
    logic              r_ov;   // output register full
    t_result           r_res;
    logic              r_done; // resize result still to be produced in S_OUT

    logic              slot_ok;
    logic [SIDX_W-1:0] sidx;
    logic signed [AMT_W:0] newcap;
    logic signed [AMT_W:0] amt;

    assign n_state       = r_state;
    assign s_in.ready    = (r_state == S_IDLE) && !r_ov;
    assign m_out.valid   = r_ov;
    assign m_out.payload = r_res;

    assign sidx    = SIDX_W'(r_item.slot - SLOT_W'(1));
    assign slot_ok = (r_item.slot >= SLOT_W'(1)) && (r_item.slot <= SLOT_W'(NUM_SLOTS));
    assign amt     = (AMT_W+1)'(signed'(r_item.amount));
    assign newcap  = signed'({1'b0, r_cap[r_s][FILL_W-1:0]} & (AMT_W+1)'('1)) + amt;

    // memory requests; a read is issued only when its data can be taken
    always_comb begin
        o_mem       = '0;
        o_mem.raddr = elem_addr(r_s, r_i[EIDX_W-1:0]);
        o_mem.re    = ((r_state == S_FIND) || (r_state == S_READ)
                       || (r_state == S_SHIFT)) && (r_i < r_n)
                      && (!r_pend || !r_ov || m_out.ready);
        o_mem.wdata = (r_state == S_SHIFT) ? i_rdata : r_item.value;
        o_mem.waddr = elem_addr(r_s, r_j[EIDX_W-1:0] - EIDX_W'(1));
        if (r_state == S_CHECK && slot_ok && r_item.kind == K_INSERT
            && r_alloc[sidx] && r_fill[sidx] < r_cap[sidx]
            && r_fill[sidx] < FILL_W'(SLOT_DEPTH)) begin
            o_mem.we    = 1'b1;
            o_mem.waddr = elem_addr(sidx, r_fill[sidx][EIDX_W-1:0]);
        end else if (r_state == S_SHIFT && r_pend) begin
            o_mem.we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_alloc[k] <= 1'b0;
                r_cap[k]   <= '0;
                r_fill[k]  <= '0;
            end
        end else begin
            if (m_out.valid && m_out.ready) r_ov <= 1'b0;
            // read data stays pending while the output register is stalled
            r_pend <= o_mem.re || (r_pend && r_ov && !m_out.ready);
            if (o_mem.re) r_j <= r_i;
            if (o_mem.re) r_i <= r_i + FILL_W'(1);
            unique case (r_state)
                S_IDLE: begin
                    if (s_in.valid && s_in.ready) begin
                        r_item  <= s_in.payload;
                        r_state <= (s_in.payload.kind > K_READ) ? S_IDLE : S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_s          <= sidx;
                    r_n          <= r_fill[sidx];
                    r_i          <= '0;
                    r_ov         <= 1'b1;
                    r_res.data   <= '0;
                    r_res.last   <= 1'b1;
                    r_res.fill   <= slot_ok ? r_fill[sidx] : '0;
                    r_state      <= S_OUT;
                    if (r_item.kind == K_CREATE && signed'(r_item.amount) < AMT_W'(1)) begin
                        r_res.status <= ST_BAD_SIZE;
                    end else if (!slot_ok) begin
                        r_res.status <= ST_BAD_SLOT;
                    end else if (r_item.kind == K_CREATE) begin
                        if (r_alloc[sidx]) r_res.status <= ST_EXISTS;
                        else if (signed'(r_item.amount) > AMT_W'(SLOT_DEPTH))
                            r_res.status <= ST_NO_MEMORY;
                        else begin
                            r_res.status  <= ST_OK;
                            r_res.fill    <= '0;
                            r_alloc[sidx] <= 1'b1;
                            r_cap[sidx]   <= FILL_W'(r_item.amount);
                            r_fill[sidx]  <= '0;
                        end
                    end else if (!r_alloc[sidx]) begin
                        r_res.status <= ST_NO_LIST;
                    end else begin
                        unique case (r_item.kind)
                            K_INSERT: begin
                                if (o_mem.we) begin
                                    r_res.status <= ST_OK;
                                    r_res.fill   <= r_fill[sidx] + FILL_W'(1);
                                    r_fill[sidx] <= r_fill[sidx] + FILL_W'(1);
                                end else r_res.status <= ST_FULL;
                            end
                            K_DELL, K_DELV: begin
                                if (r_fill[sidx] == '0) r_res.status <= ST_EMPTY;
                                else if (r_item.kind == K_DELL) begin
                                    r_res.status <= ST_OK;
                                    r_res.fill   <= r_fill[sidx] - FILL_W'(1);
                                    r_fill[sidx] <= r_fill[sidx] - FILL_W'(1);
                                end else begin
                                    r_ov    <= 1'b0;
                                    r_state <= S_FIND;
                                end
                            end
                            K_RESIZE: r_state <= S_OUT;
                            default: begin
                                r_res.status <= ST_OK;
                                if (r_fill[sidx] != '0) begin
                                    r_ov    <= 1'b0;
                                    r_state <= S_READ;
                                end
                            end
                        endcase
                        if (r_item.kind == K_RESIZE) begin
                            r_ov    <= 1'b0;
                            r_state <= S_OUT;
                            r_done  <= 1'b1;
                        end
                    end
                end
                S_FIND: begin
                    if (r_pend) begin
                        if (i_rdata == r_item.value) begin
                            // match at r_j: shift words above it down by one
                            r_i     <= r_j + FILL_W'(1);
                            r_pend  <= 1'b0;
                            r_state <= S_SHIFT;
                        end else if (r_j + FILL_W'(1) == r_n) begin
                            r_res.status <= ST_NOT_FOUND;
                            r_res.fill   <= r_n;
                            r_res.data   <= '0;
                            r_res.last   <= 1'b1;
                            r_ov         <= 1'b1;
                            r_pend       <= 1'b0;
                            r_state      <= S_OUT;
                        end
                    end
                end
                S_SHIFT: begin
                    if (!o_mem.re && !r_pend) begin
                        r_fill[r_s]  <= r_n - FILL_W'(1);
                        r_res.status <= ST_OK;
                        r_res.fill   <= r_n - FILL_W'(1);
                        r_res.data   <= '0;
                        r_res.last   <= 1'b1;
                        r_ov         <= 1'b1;
                        r_state      <= S_OUT;
                    end
                end
                S_READ: begin
                    // take the word once the output register is free
                    if (r_pend && (!r_ov || m_out.ready)) begin
                        r_res.status <= ST_OK;
                        r_res.fill   <= r_n;
                        r_res.data   <= i_rdata;
                        r_res.last   <= (r_j + FILL_W'(1) == r_n);
                        r_ov         <= 1'b1;
                        if (r_j + FILL_W'(1) == r_n) r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (r_done) begin
                        // resize result
                        r_done       <= 1'b0;
                        r_ov         <= 1'b1;
                        r_res.data   <= '0;
                        r_res.last   <= 1'b1;
                        r_res.fill   <= r_n;
                        if (newcap < (AMT_W+1)'(1)) r_res.status <= ST_BAD_NEW_SIZE;
                        else if (newcap > (AMT_W+1)'(SLOT_DEPTH))
                            r_res.status <= ST_NO_MEMORY;
                        else begin
                            r_res.status <= ST_OK;
                            r_cap[r_s]   <= FILL_W'(newcap);
                            if (r_n > FILL_W'(newcap)) begin
                                r_fill[r_s] <= FILL_W'(newcap);
                                r_res.fill  <= FILL_W'(newcap);
                            end
                        end
                    end else if (!r_ov || (m_out.valid && m_out.ready)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### src/slotted_bounded_list_table.sv
// Create, insert, delete-last and errors give their result from the check state,
// resize from the output state; read and a failed search walk the slot's n
// words (n = slot fill), and a delete-value that finds its word then shifts
// the words above it down; the RAM walks one word per cycle unless a read
// result stalls. One item is taken at a time. Reset (synchronous, active low)
// clears all slot descriptors; the element memory is not cleared.
// ----------------------------------------------------------------------------
// slotted_bounded_list_table: top level
// Sequencer plus the element memory of all slots.
// ----------------------------------------------------------------------------
module slotted_bounded_list_table (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sblt_item_if.sink     s_in,
    sblt_result_if.source m_out
);
    import sblt_pkg::*;

    t_mem_req          mem;
    logic [DATA_W-1:0] rdata;

    sblt_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in),
        .m_out   (m_out),
        .o_mem   (mem),
        .i_rdata (rdata)
    );

    sblt_ram #(.WIDTH(DATA_W), .DEPTH(MEM_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_waddr (mem.waddr),
        .i_wdata (mem.wdata),
        .i_re    (mem.re),
        .i_raddr (mem.raddr),
        .o_rdata (rdata)
    );
endmodule

### src/sblt_checker.sv
// ----------------------------------------------------------------------------
// sblt_checker: port-level checks
// Output stability, status range, fill bound, no input while a result is pending,
// and last set with data zero on error results.
module sblt_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input sblt_pkg::t_result     out_payload
);
    import sblt_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("result changed while stalled");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_payload.status <= ST_NO_MEMORY)
        else $error("status out of range");
    a_errlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_payload.status != ST_OK |-> out_payload.last
        && out_payload.data == '0)
        else $error("error result not single");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_payload.fill <= FILL_W'(SLOT_DEPTH))
        else $error("fill beyond depth");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");
endmodule

bind slotted_bounded_list_table sblt_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_ready    (s_in.ready),
    .out_valid   (m_out.valid),
    .out_ready   (m_out.ready),
    .out_payload (m_out.payload)
);
